// ===== design/mse_pkg.sv =====
// mse_pkg: shared types and constants for the MIPS subset execute block.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package mse_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_ADDR  = 2'd2,
    ST_NOSUP = 2'd3
  } status_t;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] FN_ADD     = 6'h20;

  // output-character window 0x30000004..0x30000007, as a word address
  localparam logic [29:0] CHAR_WORD = 30'h0C00_0001;

  typedef struct packed {
    status_t     status;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [2:0]  char_count;
    logic [31:0] char_bytes;
  } res_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] val;
  } rf_wr_t;

  // byte i of data goes to data memory when byte_en[i]
  typedef struct packed {
    logic [3:0]  byte_en;
    logic [31:0] data;
  } st_req_t;

endpackage

`default_nettype wire

// ===== design/mse_if.sv =====
// mse_in_if / mse_out_if: valid/ready channels of the execute block.
// Depends on mse_pkg for the status type.
`default_nettype none

interface mse_in_if;
  import mse_pkg::*;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;
  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface mse_out_if;
  import mse_pkg::*;
  logic        valid;
  logic        ready;
  status_t     status;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic [2:0]  char_count;
  logic [31:0] char_bytes;
  modport source (output valid, output status, output reg_written, output reg_index,
                  output reg_value, output char_count, output char_bytes, input ready);
  modport sink   (input valid, input status, input reg_written, input reg_index,
                  input reg_value, input char_count, input char_bytes, output ready);
endinterface

`default_nettype wire

// ===== design/mse_regfile.sv =====
// mse_regfile: 32 x 32 register file, two registered read ports, one write port.
// Depends on mse_pkg (rf_wr_t). Entries not yet written read as zero.
`default_nettype none

module mse_regfile (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            rd_en,
  input  wire logic [4:0]      rs_idx,
  input  wire logic [4:0]      rt_idx,
  input  wire mse_pkg::rf_wr_t wr,
  output logic [31:0]          a_r,
  output logic [31:0]          b_r
);
  import mse_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] vld_r;
  logic [31:0] vld_nxt;

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) vld_nxt[wr.idx] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.idx] <= wr.val;
  end

  // read at accept; forward a write landing on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.idx == rs_idx) a_r <= wr.val;
      else a_r <= vld_r[rs_idx] ? mem[rs_idx] : 32'd0;
      if (wr.en && wr.idx == rt_idx) b_r <= wr.val;
      else b_r <= vld_r[rt_idx] ? mem[rt_idx] : 32'd0;
    end
  end

endmodule

`default_nettype wire

// ===== design/mse_exec.sv =====
// mse_exec: decode and execute of one instruction from its operands.
// Depends on mse_pkg. Pure logic between the operand and result registers.
`default_nettype none

module mse_exec #(
  parameter int unsigned DATA_BYTES = 65536,
  parameter logic [31:0] DATA_BASE  = 32'h2000_0000,
  localparam int         OFF_W      = $clog2(DATA_BYTES)
) (
  input  wire logic [31:0]       instr,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output mse_pkg::res_t          res,
  output mse_pkg::rf_wr_t        wr,
  output mse_pkg::st_req_t       st,
  output logic [3:0][OFF_W-1:0]  st_off
);
  import mse_pkg::*;

  localparam logic [32:0] DEND = {1'b0, DATA_BASE} + 33'(DATA_BYTES) - 33'd1;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] simm;
  logic [31:0] sum_rr;
  logic [31:0] sum_ri;
  logic        ovf_rr;
  logic        ovf_ri;
  logic [3:0]  mask;
  logic        misalign;
  logic        in_char;
  logic [3:0][31:0] addr_b;
  logic [3:0]  in_data;
  logic [3:0]  bad;
  logic        st_ok;
  logic [3:0]  char_en;
  logic [2:0]  cnt;
  logic [31:0] chars;
  logic [31:0] rel;
  status_t     status;
  logic        do_wr;
  logic [4:0]  wr_idx;
  logic [31:0] wr_val;

  assign op     = instr[31:26];
  assign fn     = instr[5:0];
  assign rt     = instr[20:16];
  assign rd     = instr[15:11];
  assign simm   = {{16{instr[15]}}, instr[15:0]};
  assign sum_rr = a + b;
  assign sum_ri = a + simm;
  assign ovf_rr = (a[31] ^ sum_rr[31]) & (b[31] ^ sum_rr[31]);
  assign ovf_ri = (a[31] ^ sum_ri[31]) & (simm[31] ^ sum_ri[31]);

  always_comb begin
    status = ST_OK;
    do_wr  = 1'b0;
    wr_idx = rt;
    wr_val = sum_ri;
    mask   = 4'b0000;
    unique case (op)
      OP_SPECIAL: begin
        if (fn != FN_ADD) status = ST_NOSUP;
        else if (ovf_rr) status = ST_OVF;
        else begin
          do_wr  = 1'b1;
          wr_idx = rd;
          wr_val = sum_rr;
        end
      end
      OP_ADDI: begin
        if (ovf_ri) status = ST_OVF;
        else do_wr = 1'b1;
      end
      OP_ADDIU: do_wr = 1'b1;
      OP_LUI: begin
        do_wr  = 1'b1;
        wr_val = {instr[15:0], 16'd0};
      end
      OP_SB:   mask = 4'b0001;
      OP_SH:   mask = 4'b0011;
      OP_SW:   mask = 4'b1111;
      default: status = ST_NOSUP;
    endcase
  end

  // aligned stores stay inside one word, so byte i sits at addr | i
  assign misalign = (mask[1] & sum_ri[0]) | (mask[3] & sum_ri[1]);
  assign in_char  = sum_ri[31:2] == CHAR_WORD;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      addr_b[i]  = {sum_ri[31:2], sum_ri[1:0] | 2'(i)};
      in_data[i] = (addr_b[i] >= DATA_BASE) && ({1'b0, addr_b[i]} <= DEND);
      bad[i]     = mask[i] & ~in_data[i] & ~in_char;
    end
  end

  assign st_ok   = (mask != 4'b0000) && !misalign && (bad == 4'b0000);
  assign char_en = st_ok ? (mask & ~in_data) : 4'b0000;

  // char bytes packed from lane 0 in address order
  always_comb begin
    cnt   = 3'd0;
    chars = 32'd0;
    for (int i = 0; i < 4; i++) begin
      if (char_en[i]) begin
        chars = chars | (32'(b[8*i +: 8]) << {cnt[1:0], 3'b000});
        cnt   = cnt + 3'd1;
      end
    end
  end

  assign rel = sum_ri - DATA_BASE;

  // the window base need not be word aligned, so offsets are summed
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      st_off[i] = rel[OFF_W-1:0] + OFF_W'(i);
    end
  end

  assign st.byte_en = st_ok ? (mask & in_data) : 4'b0000;
  assign st.data    = b;

  always_comb begin
    res = '0;
    wr  = '0;
    if (mask != 4'b0000 && !st_ok) begin
      res.status = ST_ADDR;
    end else if (status != ST_OK) begin
      res.status = status;
    end else begin
      res.status     = ST_OK;
      res.char_count = cnt;
      res.char_bytes = chars;
      if (do_wr && wr_idx != 5'd0) begin
        res.reg_written = 1'b1;
        res.reg_index   = wr_idx;
        res.reg_value   = wr_val;
        wr.en           = 1'b1;
        wr.idx          = wr_idx;
        wr.val          = wr_val;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mse_dmem.sv =====
// mse_dmem: byte data memory as four byte-wide banks, one store per cycle.
// Depends on mse_pkg (st_req_t). Store-only: the block has no load path.
`default_nettype none

module mse_dmem #(
  parameter int unsigned DATA_BYTES = 65536,
  localparam int         OFF_W      = $clog2(DATA_BYTES)
) (
  input  wire logic                      clk,
  input  wire mse_pkg::st_req_t          st,
  input  wire logic [3:0][OFF_W-1:0]     st_off
);
  import mse_pkg::*;

  localparam int ROWS  = (DATA_BYTES + 3) / 4;
  localparam int ROW_W = (OFF_W > 2) ? OFF_W - 2 : 1;

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0]       bank [ROWS];
    logic             we;
    logic [ROW_W-1:0] row;
    logic [7:0]       wbyte;

    // consecutive bytes of one store fall in distinct banks
    always_comb begin
      we    = 1'b0;
      row   = '0;
      wbyte = 8'd0;
      for (int i = 0; i < 4; i++) begin
        if (st.byte_en[i] && st_off[i][1:0] == 2'(g)) begin
          we    = 1'b1;
          row   = ROW_W'(st_off[i] >> 2);
          wbyte = st.data[8*i +: 8];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (we) bank[row] <= wbyte;
    end
  end

endmodule

`default_nettype wire

// ===== design/mips_subset_execute.sv =====
// mips_subset_execute: top level of the MIPS subset execute block.
// Depends on mse_pkg, mse_if, mse_regfile, mse_exec and mse_dmem.
`default_nettype none

// Executes add, addi, addiu, lui, sb, sh and sw, one instruction word per
// cycle sustained while out_chan is ready. A word accepted at one edge has
// its register operands read into the operand stage at that edge; the
// result word is offered once it enters the output register, where the
// register file and data memory are also written at that edge. A write is
// forwarded to a word accepted at the same edge, so dependent instructions
// may follow back to back. The output register decouples the two sides: a
// new word is taken while a result waits; one write port sets throughput.
module mips_subset_execute #(
  parameter int unsigned DATA_BYTES = 65536,
  parameter logic [31:0] DATA_BASE  = 32'h2000_0000
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mse_in_if.sink    in_chan,
  mse_out_if.source out_chan
);
  import mse_pkg::*;

  localparam int OFF_W = $clog2(DATA_BYTES);

  logic                   v1_r;
  logic                   v1_nxt;
  logic [31:0]            instr_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  res_t                   res_r;
  logic                   accept;
  logic                   adv;
  logic [31:0]            a_r;
  logic [31:0]            b_r;
  res_t                   res;
  rf_wr_t                 wr;
  rf_wr_t                 wr_g;
  st_req_t                st;
  st_req_t                st_g;
  logic [3:0][OFF_W-1:0]  st_off;

  assign adv            = v1_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !v1_r || adv;
  assign accept         = in_chan.valid && in_chan.ready;

  assign v1_nxt         = accept ? 1'b1 : (adv ? 1'b0 : v1_r);
  assign out_valid_nxt  = adv ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) instr_r <= in_chan.instruction;
    if (adv) res_r <= res;
  end

  always_comb begin
    wr_g         = wr;
    wr_g.en      = wr.en & adv;
    st_g         = st;
    st_g.byte_en = adv ? st.byte_en : 4'b0000;
  end

  mse_regfile u_rf (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rs_idx (in_chan.instruction[25:21]),
    .rt_idx (in_chan.instruction[20:16]),
    .wr     (wr_g),
    .a_r    (a_r),
    .b_r    (b_r)
  );

  mse_exec #(
    .DATA_BYTES (DATA_BYTES),
    .DATA_BASE  (DATA_BASE)
  ) u_exec (
    .instr  (instr_r),
    .a      (a_r),
    .b      (b_r),
    .res    (res),
    .wr     (wr),
    .st     (st),
    .st_off (st_off)
  );

  mse_dmem #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dmem (
    .clk    (clk),
    .st     (st_g),
    .st_off (st_off)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = res_r.status;
  assign out_chan.reg_written = res_r.reg_written;
  assign out_chan.reg_index   = res_r.reg_index;
  assign out_chan.reg_value   = res_r.reg_value;
  assign out_chan.char_count  = res_r.char_count;
  assign out_chan.char_bytes  = res_r.char_bytes;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for mips_subset_execute (add/addi/addiu/lui, sb/sh/sw).
// Needs mse_pkg, mse_if and the RTL of the block; it keeps its own shadow of the
// register file and data memory and checks every retired word against it.
`timescale 1ns / 1ps

module tb_top;
  import mse_pkg::*;

  localparam logic [31:0] DATA_BASE  = 32'h2000_0000;
  localparam logic [31:0] DATA_BYTES = 32'd65536;
  localparam int          STALL_LIMIT = 1000;

  // opcodes outside the supported subset, used to exercise the rejection path
  localparam logic [5:0] OP_J  = 6'h02;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] FN_JR = 6'h08;

  logic clk = 1'b0;
  logic rst_n;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  mips_subset_execute uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow architectural state
  logic [31:0] arch_regs   [32];
  logic [7:0]  data_shadow [65536];

  res_t retire_q [$];

  int src_idle_pct;
  int snk_idle_pct;
  int words_sent;
  int directed_words;
  int results_seen;
  int mismatches;
  int errors;
  int stall_cycles;
  int n_ovf, n_addr, n_nosup, n_char, n_regwr;

  function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
                                        input logic [4:0] rd, input logic [4:0] sh,
                                        input logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Executes one word against the shadow state and returns what should retire.
  function automatic res_t execute_insn(input logic [31:0] w);
    res_t        r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs, rt, rd;
    logic [31:0] simm, a, b, sum, addr, ba, off;
    logic        wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        bad;
    int          nb;
    int          cnt;
    r    = '0;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    fn   = w[5:0];
    simm = {{16{w[15]}}, w[15:0]};
    a    = (rs == 5'd0) ? 32'd0 : arch_regs[rs];
    b    = (rt == 5'd0) ? 32'd0 : arch_regs[rt];
    wr   = 1'b0;
    widx = 5'd0;
    wval = 32'd0;
    nb   = 0;
    cnt  = 0;
    r.status = ST_OK;
    case (op)
      OP_SPECIAL: begin
        if (fn == FN_ADD) begin
          sum = a + b;
          if (((a ^ sum) & (b ^ sum)) >> 31) r.status = ST_OVF;
          else begin
            wr = 1'b1; widx = rd; wval = sum;
          end
        end else begin
          r.status = ST_NOSUP;
        end
      end
      OP_ADDI: begin
        sum = a + simm;
        if (((a ^ sum) & (simm ^ sum)) >> 31) r.status = ST_OVF;
        else begin
          wr = 1'b1; widx = rt; wval = sum;
        end
      end
      OP_ADDIU: begin
        wr = 1'b1; widx = rt; wval = a + simm;
      end
      OP_LUI: begin
        wr = 1'b1; widx = rt; wval = {w[15:0], 16'h0000};
      end
      OP_SB: nb = 1;
      OP_SH: nb = 2;
      OP_SW: nb = 4;
      default: r.status = ST_NOSUP;
    endcase
    if (nb != 0) begin
      addr = a + simm;
      bad  = (addr & (nb - 1)) != 0;
      for (int i = 0; i < nb; i++) begin
        ba = addr + i;
        if (!((ba >= DATA_BASE && (ba - DATA_BASE) < DATA_BYTES) || ba[31:2] == CHAR_WORD))
          bad = 1'b1;
      end
      if (bad) begin
        r.status = ST_ADDR;
      end else begin
        for (int i = 0; i < nb; i++) begin
          ba = addr + i;
          if (ba >= DATA_BASE && (ba - DATA_BASE) < DATA_BYTES) begin
            off = ba - DATA_BASE;
            data_shadow[off[15:0]] = b[8*i +: 8];
          end else begin
            r.char_bytes[8*cnt +: 8] = b[8*i +: 8];
            cnt++;
          end
        end
        r.char_count = 3'(cnt);
      end
    end
    // r0 writes vanish; traps leave the state alone
    if (r.status == ST_OK && wr && widx != 5'd0) begin
      arch_regs[widx] = wval;
      r.reg_written   = 1'b1;
      r.reg_index     = widx;
      r.reg_value     = wval;
    end
    return r;
  endfunction

  // Random word, biased toward legal sequences: base-pointer setup, arithmetic
  // and stores aimed at the edges of both windows, plus raw noise.
  function automatic logic [31:0] rand_word();
    int          pick;
    int          nb;
    logic [4:0]  rs, rt, rd;
    logic [15:0] imm, mask;
    logic [5:0]  op;
    pick = $urandom_range(0, 99);
    rs   = 5'($urandom_range(0, 31));
    rt   = 5'($urandom_range(0, 31));
    rd   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) :
                                         5'($urandom_range(5, 31));
    imm  = 16'($urandom_range(0, 16'hFFFF));
    if (pick < 8) begin
      case ($urandom_range(0, 2))
        0:       return enc_i(OP_LUI, 5'd0, 5'd1, 16'h2000);
        1:       return enc_i(OP_LUI, 5'd0, 5'd2, 16'h2001);
        default: return enc_i(OP_LUI, 5'd0, 5'd3, 16'h3000);
      endcase
    end else if (pick < 20) begin
      return enc_r(rs, rt, rd, 5'($urandom_range(0, 31)), FN_ADD);
    end else if (pick < 30) begin
      return enc_i(OP_ADDI, rs, rd, imm);
    end else if (pick < 38) begin
      return enc_i(OP_ADDIU, rs, rd, imm);
    end else if (pick < 45) begin
      case ($urandom_range(0, 3))
        0: imm = 16'h7FFF;
        1: imm = 16'h8000;
        2: imm = 16'hFFFF;
        default: ;
      endcase
      return enc_i(OP_LUI, rs, rd, imm);
    end else if (pick < 85) begin
      case ($urandom_range(0, 2))
        0:       begin op = OP_SB; nb = 1; end
        1:       begin op = OP_SH; nb = 2; end
        default: begin op = OP_SW; nb = 4; end
      endcase
      case ($urandom_range(0, 3))
        0: begin rs = 5'd1; imm = 16'($urandom_range(0, 16'h7FFF)); end
        1: begin rs = 5'd2; imm = 16'($urandom_range(1, 16)); imm = -imm; end
        2: begin rs = 5'd3; imm = 16'($urandom_range(0, 12)); end
        default: ;
      endcase
      mask = 16'(nb - 1);
      if ($urandom_range(0, 99) < 85) imm = imm & ~mask;
      return enc_i(op, rs, rt, imm);
    end else if (pick < 93) begin
      return $urandom;
    end
    return enc_r(rs, rt, rd, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
  endfunction

  // Drives one word; entered and left just after a falling edge.
  task automatic send_word(input logic [31:0] w);
    while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.instruction = w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    retire_q.push_back(execute_insn(w));
    words_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic wait_retired();
    while (retire_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("MISMATCH %s: exp st=%s wr=%0d idx=%0d val=%h cc=%0d cb=%h",
               what, want.status.name(), want.reg_written, want.reg_index,
               want.reg_value, want.char_count, want.char_bytes);
      $display("  got st=%s wr=%0d idx=%0d val=%h cc=%0d cb=%h",
               got.status.name(), got.reg_written, got.reg_index, got.reg_value,
               got.char_count, got.char_bytes);
    end
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status      = out_ch.status;
      got.reg_written = out_ch.reg_written;
      got.reg_index   = out_ch.reg_index;
      got.reg_value   = out_ch.reg_value;
      got.char_count  = out_ch.char_count;
      got.char_bytes  = out_ch.char_bytes;
      results_seen++;
      if (retire_q.size() == 0) begin
        report_mismatch("unexpected word", '0, got);
      end else begin
        want = retire_q.pop_front();
        if (got.status !== want.status || got.reg_written !== want.reg_written ||
            got.reg_index !== want.reg_index || got.reg_value !== want.reg_value ||
            got.char_count !== want.char_count || got.char_bytes !== want.char_bytes)
          report_mismatch("field", want, got);
        case (want.status)
          ST_OVF:   n_ovf++;
          ST_ADDR:  n_addr++;
          ST_NOSUP: n_nosup++;
          default: begin
            if (want.char_count != 0) n_char++;
            if (want.reg_written) n_regwr++;
          end
        endcase
      end
    end
  end

  // no handshake on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results pending",
               STALL_LIMIT, retire_q.size());
      $display("mips_subset_execute test failed");
      $finish;
    end
  end

  task automatic test_arith_corners();
    send_word(enc_i(OP_LUI, 5'd0, 5'd6, 16'h8000));
    send_word(enc_i(OP_ADDIU, 5'd6, 5'd6, 16'hFFFF));            // r6 = max positive
    send_word(enc_i(OP_ADDI, 5'd6, 5'd7, 16'h0001));             // positive overflow
    send_word(enc_r(5'd6, 5'd6, 5'd0, 5'd5, FN_ADD));            // trap even into r0
    send_word(enc_i(OP_ADDIU, 5'd6, 5'd0, 16'h0001));            // r0 write dropped
    send_word(enc_i(OP_LUI, 5'd0, 5'd8, 16'h8000));              // r8 = min negative
    send_word(enc_i(OP_ADDI, 5'd8, 5'd9, 16'hFFFF));             // negative overflow
    send_word(enc_r(5'd8, 5'd6, 5'd10, 5'd31, FN_ADD));          // shamt ignored
    send_word(enc_i(OP_ADDI, 5'd10, 5'd11, 16'h7FFF));
  endtask

  task automatic test_store_windows();
    send_word(enc_i(OP_LUI, 5'd0, 5'd1, 16'h2000));
    send_word(enc_i(OP_LUI, 5'd0, 5'd2, 16'h2001));
    send_word(enc_i(OP_LUI, 5'd0, 5'd3, 16'h3000));
    send_word(enc_i(OP_SW, 5'd1, 5'd6, 16'h0000));               // bottom of data window
    send_word(enc_i(OP_SH, 5'd2, 5'd10, 16'hFFFE));              // top of data window
    send_word(enc_i(OP_SH, 5'd1, 5'd6, 16'h0001));               // misaligned
    send_word(enc_i(OP_SB, 5'd2, 5'd6, 16'h0000));               // just past the window
    send_word(enc_i(OP_SW, 5'd1, 5'd6, 16'hFFFC));               // just below the window
    send_word(enc_i(OP_SW, 5'd3, 5'd6, 16'h0004));               // four chars
    send_word(enc_i(OP_SH, 5'd3, 5'd6, 16'h0006));
    send_word(enc_i(OP_SB, 5'd3, 5'd10, 16'h0007));
    send_word(enc_i(OP_SH, 5'd3, 5'd6, 16'h0002));               // below char window
    send_word(enc_i(OP_SW, 5'd3, 5'd6, 16'h0008));               // above char window
  endtask

  task automatic test_unsupported();
    send_word(enc_i(OP_J, 5'd3, 5'd1, 16'h1234));
    send_word(enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR));
    send_word(enc_i(OP_LW, 5'd1, 5'd12, 16'h0000));
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
  endtask

  task automatic test_random_mix(input int n, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) send_word(rand_word());
    wait_retired();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.instruction = 32'd0;
    src_idle_pct      = 36;
    snk_idle_pct      = 52;
    words_sent        = 0;
    errors            = 0;
    foreach (arch_regs[i]) arch_regs[i] = 32'd0;
    foreach (data_shadow[i]) data_shadow[i] = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_arith_corners();
    test_store_windows();
    test_unsupported();
    wait_retired();
    directed_words = words_sent;

    test_random_mix(250, 36, 52);
    test_random_mix(250, 52, 36);
    test_random_mix(250, 0, 0);

    repeat (4) @(posedge clk);
    errors = mismatches + retire_q.size();
    if (retire_q.size() != 0)
      $display("%0d expected results never arrived", retire_q.size());
    $display("sent %0d words (%0d directed), %0d results: %0d reg writes, %0d char stores",
             words_sent, directed_words, results_seen, n_regwr, n_char);
    $display("traps seen: %0d overflow, %0d address, %0d unsupported; %0d mismatches",
             n_ovf, n_addr, n_nosup, mismatches);
    if (errors == 0)
      $display("mips_subset_execute test passed");
    else
      $display("mips_subset_execute test failed");
    $finish;
  end

endmodule
